FILE: sv/gbr_pkg.sv
// Shared constants, character codes and types for the go-back-N receiver
// with checksum check. No dependencies; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package gbr_pkg;

  // Default configuration and fixed field widths.
  localparam int unsigned CLIENTS_DEF  = 16;
  localparam int unsigned SEQ_BITS_DEF = 16;
  localparam int unsigned CLIENT_W     = 4;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned ACK_W        = 16;
  localparam int unsigned CSUM_W       = 8;

  // Entries in the queue between parser and sequence tracker (power of two).
  localparam int unsigned QUEUE_DEPTH  = 2;

  // Characters of the datagram text form.
  localparam logic [BYTE_W-1:0] CHAR_BAR  = 8'h7C;  // '|'
  localparam logic [BYTE_W-1:0] CHAR_PAD  = 8'h23;  // '#'
  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;  // '9'

  // Byte sum of the acknowledgement payload "ACK".
  localparam logic [CSUM_W-1:0] ACK_PAYLOAD_SUM = 8'd207;

  // Parser phase, one-hot.
  typedef enum logic [4:0] {
    PH_SEQ = 5'b00001,
    PH_ACK = 5'b00010,
    PH_CHK = 5'b00100,
    PH_PAY = 5'b01000,
    PH_PAD = 5'b10000
  } phase_e;

  // Checksum of an acknowledgement with seq 0, the given ack number and
  // payload "ACK": 255 minus the byte sum, which is the bitwise inverse.
  function automatic logic [CSUM_W-1:0] ack_csum(input logic [CSUM_W-1:0] ack_lo);
    logic [CSUM_W-1:0] sum;
    sum = ack_lo + ACK_PAYLOAD_SUM;
    return ~sum;
  endfunction

endpackage

`default_nettype wire

FILE: sv/gbr_front.sv
// Byte parser of the go-back-N receiver: splits seq|ack|checksum|payload,
// checks format and checksum, and hands good packets on. Uses gbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbr_front import gbr_pkg::*; #(
  parameter int unsigned CLIENTS  = CLIENTS_DEF,
  parameter int unsigned SEQ_BITS = SEQ_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                byte_valid_i,
  output logic                     byte_ready_o,
  input  wire logic [BYTE_W-1:0]   byte_i,
  input  wire logic [CLIENT_W-1:0] client_i,
  input  wire logic                last_i,
  input  wire logic                pkt_ready_i,
  output logic                     pkt_valid_o,
  output logic [CLIENT_W-1:0]      pkt_client_o,
  output logic [SEQ_BITS-1:0]      pkt_seq_o
);

  // Accumulators hold one bit above the sequence range and saturate there.
  localparam int unsigned ACC_W  = SEQ_BITS + 1;
  localparam int unsigned PROD_W = SEQ_BITS + 5;
  localparam logic [PROD_W-1:0] SEQ_LIMIT = (PROD_W'(1) << SEQ_BITS) - PROD_W'(1);
  localparam logic [ACC_W-1:0]  ACC_SAT   = ACC_W'(1) << SEQ_BITS;

  phase_e            phase_q, phase_d;
  logic [ACC_W-1:0]  seq_q, seq_d;
  logic [ACC_W-1:0]  ack_q, ack_d;
  logic [ACC_W-1:0]  chk_q, chk_d;
  logic [BYTE_W-1:0] sum_q, sum_d;
  logic              digit_q, digit_d;
  logic              bad_q, bad_d;

  logic              take;
  logic              is_bar, is_pad, is_digit;
  logic [3:0]        digit_val;
  logic [ACC_W-1:0]  acc_sel, acc_new;
  logic [PROD_W-1:0] prod;
  logic              sat;
  logic [CSUM_W-1:0] want;
  logic              check_ok, client_ok, payload_seen;

  // The whole front stalls while the queue cannot take a packet.
  assign byte_ready_o = pkt_ready_i;
  assign take         = byte_valid_i & byte_ready_o;

  assign is_bar    = (byte_i == CHAR_BAR);
  assign is_pad    = (byte_i == CHAR_PAD);
  assign is_digit  = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);
  assign digit_val = 4'(byte_i - CHAR_ZERO);

  // One shared decimal digit step: acc * 10 + digit, as shift and add.
  always_comb begin
    unique case (phase_q)
      PH_SEQ:  acc_sel = seq_q;
      PH_ACK:  acc_sel = ack_q;
      default: acc_sel = chk_q;
    endcase
    prod    = (PROD_W'(acc_sel) << 3) + (PROD_W'(acc_sel) << 1) + PROD_W'(digit_val);
    sat     = (prod > SEQ_LIMIT);
    acc_new = sat ? ACC_SAT : prod[ACC_W-1:0];
  end

  // Parser state update for the byte on the input.
  always_comb begin
    phase_d = phase_q;
    seq_d   = seq_q;
    ack_d   = ack_q;
    chk_d   = chk_q;
    sum_d   = sum_q;
    digit_d = digit_q;
    bad_d   = bad_q;
    unique case (phase_q)
      PH_SEQ, PH_ACK, PH_CHK: begin
        if (is_bar) begin
          if (!digit_q) begin
            bad_d = 1'b1;
          end
          digit_d = 1'b0;
          unique case (phase_q)
            PH_SEQ:  phase_d = PH_ACK;
            PH_ACK:  phase_d = PH_CHK;
            default: phase_d = PH_PAY;
          endcase
        end else if (is_digit) begin
          digit_d = 1'b1;
          if (sat) begin
            bad_d = 1'b1;
          end
          unique case (phase_q)
            PH_SEQ:  seq_d = acc_new;
            PH_ACK:  ack_d = acc_new;
            default: chk_d = acc_new;
          endcase
        end else begin
          bad_d = 1'b1;
        end
      end
      PH_PAY: begin
        if (is_pad) begin
          phase_d = PH_PAD;
        end else begin
          sum_d = sum_q + byte_i;
        end
      end
      default: begin
        // Bytes after the pad mark are ignored.
      end
    endcase
  end

  // Packet verdict on the last byte.
  always_comb begin
    want         = ~(CSUM_W'(seq_d) + CSUM_W'(ack_d) + sum_d);
    check_ok     = (32'(chk_d) == 32'(want));
    client_ok    = (32'(client_i) < CLIENTS);
    payload_seen = (phase_d == PH_PAY) || (phase_d == PH_PAD);
  end

  assign pkt_valid_o  = take & last_i & ~bad_d & payload_seen & client_ok & check_ok;
  assign pkt_client_o = client_i;
  assign pkt_seq_o    = seq_d[SEQ_BITS-1:0];

  // The parser returns to its start state after every last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEQ;
      seq_q   <= '0;
      ack_q   <= '0;
      chk_q   <= '0;
      sum_q   <= '0;
      digit_q <= 1'b0;
      bad_q   <= 1'b0;
    end else if (take) begin
      if (last_i) begin
        phase_q <= PH_SEQ;
        seq_q   <= '0;
        ack_q   <= '0;
        chk_q   <= '0;
        sum_q   <= '0;
        digit_q <= 1'b0;
        bad_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        seq_q   <= seq_d;
        ack_q   <= ack_d;
        chk_q   <= chk_d;
        sum_q   <= sum_d;
        digit_q <= digit_d;
        bad_q   <= bad_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/gbr_queue.sv
// Short first-in first-out queue of accepted packets between the parser and
// the sequence tracker. Uses gbr_pkg for the default depth.
`timescale 1ns / 1ps
`default_nettype none

module gbr_queue import gbr_pkg::*; #(
  parameter int unsigned WIDTH = CLIENT_W + SEQ_BITS_DEF,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = (32'(count_q) < DEPTH);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers wrap at the depth; count tracks occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/gbr_back.sv
// Sequence tracker of the go-back-N receiver: keeps the expected sequence
// number per client and builds the acknowledgement. Uses gbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbr_back import gbr_pkg::*; #(
  parameter int unsigned CLIENTS  = CLIENTS_DEF,
  parameter int unsigned SEQ_BITS = SEQ_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                pkt_valid_i,
  output logic                     pkt_ready_o,
  input  wire logic [CLIENT_W-1:0] pkt_client_i,
  input  wire logic [SEQ_BITS-1:0] pkt_seq_i,
  output logic                     ack_valid_o,
  input  wire logic                ack_ready_i,
  output logic [CLIENT_W-1:0]      ack_client_o,
  output logic [ACK_W-1:0]         ack_number_o,
  output logic [CSUM_W-1:0]        ack_csum_o,
  output logic                     ack_in_order_o
);

  // Only indexes reachable through the client field need an entry.
  localparam int unsigned REACH       = 1 << CLIENT_W;
  localparam int unsigned STORE_DEPTH = (CLIENTS < REACH) ? CLIENTS : REACH;
  localparam int unsigned IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [SEQ_BITS-1:0] expect_q [STORE_DEPTH];
  logic                valid_q;
  logic                take;
  logic [IDX_W-1:0]    idx;
  logic [SEQ_BITS-1:0] cur, next_seq;
  logic                hit;
  logic [31:0]         ack_wide;

  // A packet moves on whenever the output register is empty or being drained.
  assign pkt_ready_o = ~valid_q | ack_ready_i;
  assign take        = pkt_valid_i & pkt_ready_o;

  always_comb begin
    idx      = pkt_client_i[IDX_W-1:0];
    cur      = expect_q[idx];
    hit      = (pkt_seq_i == cur);
    next_seq = hit ? cur + SEQ_BITS'(1) : cur;
    ack_wide = 32'(next_seq);
  end

  // Expected sequence table, read and updated in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        expect_q[i] <= '0;
      end
    end else if (take) begin
      expect_q[idx] <= next_seq;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pkt_ready_o) begin
      valid_q <= pkt_valid_i;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (take) begin
      ack_client_o   <= pkt_client_i;
      ack_number_o   <= ack_wide[ACK_W-1:0];
      ack_csum_o     <= ack_csum(ack_wide[CSUM_W-1:0]);
      ack_in_order_o <= hit;
    end
  end

  assign ack_valid_o = valid_q;

endmodule

`default_nettype wire

FILE: sv/gbn_receiver_checksum.sv
// Go-back-N receiver with packet checksum check: a byte parser, a short
// packet queue and a per-client sequence tracker. Uses gbr_pkg.
//
// Input stream (s_axis): one datagram byte per request in tdata, the sending
// client index in tuser, tlast on the final byte. Datagrams have the text
// form seq|ack|checksum|payload with decimal fields.
// Output stream (m_axis): one acknowledgement per well-formed packet whose
// checksum matches: tdata carries the ack number and its own checksum,
// tuser the client and an in-order flag. Bad packets give no output.
// Throughput: one byte per clock cycle while s_axis_tready is high; packets
// may follow each other with no gap. An acknowledgement reaches m_axis by
// way of the packet queue and then the output register behind the sequence
// table update.
// Reset clears the parser and sets every client's expected sequence number
// to zero; the block takes bytes right after reset.
// When the receiver holds off m_axis_tready, the output register and then
// the two-entry packet queue fill; only then is s_axis_tready dropped.
`timescale 1ns / 1ps
`default_nettype none

module gbn_receiver_checksum import gbr_pkg::*; #(
  parameter int unsigned CLIENTS  = CLIENTS_DEF,
  parameter int unsigned SEQ_BITS = SEQ_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  wire logic [3:0]  s_axis_tuser,   // [3:0] client_index
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [15:0] ack_number, [23:16] ack_checksum
  output logic [4:0]       m_axis_tuser    // [3:0] client_id, [4] in_order
);

  localparam int unsigned QW = CLIENT_W + SEQ_BITS;

  logic                front_valid, front_ready;
  logic [CLIENT_W-1:0] front_client;
  logic [SEQ_BITS-1:0] front_seq;
  logic                q_valid, q_ready;
  logic [QW-1:0]       q_data;
  logic [CLIENT_W-1:0] ack_client;
  logic [ACK_W-1:0]    ack_number;
  logic [CSUM_W-1:0]   ack_csum_v;
  logic                ack_in_order;

  // Byte parser and packet check.
  gbr_front #(
    .CLIENTS  (CLIENTS),
    .SEQ_BITS (SEQ_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .client_i     (s_axis_tuser),
    .last_i       (s_axis_tlast),
    .pkt_ready_i  (front_ready),
    .pkt_valid_o  (front_valid),
    .pkt_client_o (front_client),
    .pkt_seq_o    (front_seq)
  );

  // Packet queue between parser and tracker.
  gbr_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  ({front_client, front_seq}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  // Sequence tracker and acknowledgement register.
  gbr_back #(
    .CLIENTS  (CLIENTS),
    .SEQ_BITS (SEQ_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pkt_valid_i    (q_valid),
    .pkt_ready_o    (q_ready),
    .pkt_client_i   (q_data[QW-1:SEQ_BITS]),
    .pkt_seq_i      (q_data[SEQ_BITS-1:0]),
    .ack_valid_o    (m_axis_tvalid),
    .ack_ready_i    (m_axis_tready),
    .ack_client_o   (ack_client),
    .ack_number_o   (ack_number),
    .ack_csum_o     (ack_csum_v),
    .ack_in_order_o (ack_in_order)
  );

  assign m_axis_tdata = {ack_csum_v, ack_number};
  assign m_axis_tuser = {ack_in_order, ack_client};

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for gbn_receiver_checksum: feeds datagram bytes on
// s_axis and checks every acknowledgement on m_axis. Depends on gbr_pkg.
`timescale 1ns / 1ps

module tb_top;
  import gbr_pkg::*;

  localparam int unsigned SEQ_TOP        = 65535;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          RANDOM_BYTES   = 1750;
  localparam int          TAIL_CYCLES    = 12;

  // One acknowledgement as seen on m_axis.
  typedef struct packed {
    logic [3:0]  client;
    logic [15:0] ack;
    logic [7:0]  csum;
    logic        in_ord;
  } ack_t;

  // One byte request, with the hand-typed outcome of its datagram if any.
  typedef struct packed {
    logic [3:0] client;
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic       typed_has;
    ack_t       typed_exp;
  } byte_req_t;

  // One datagram of the directed table.
  typedef struct {
    string      text;
    logic [3:0] client;
    bit         mixed;
    bit         typed;
    bit         has;
    logic [15:0] ack;
    logic [7:0] csum;
    bit         in_ord;
  } dir_row_t;

  // Ways a random datagram is spoiled.
  typedef enum int {
    FL_NONE,
    FL_EMPTY,
    FL_BIG,
    FL_CHAR,
    FL_CUT,
    FL_NOISE
  } flaw_e;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  byte_req_t   cur_req = '0;
  logic        m_ready = 1'b0;
  wire         s_ready;
  wire         m_valid;
  wire  [23:0] m_tdata;
  wire  [4:0]  m_tuser;

  // Predictor state.
  phase_e      prs_phase = PH_SEQ;
  logic [16:0] fld_val [3];
  logic [7:0]  pay_sum = '0;
  bit          got_digit;
  bit          fmt_bad;
  logic [15:0] seq_expected [16];

  ack_t        ack_expect_q [$];
  logic [7:0]  dg_txt [$];
  logic [3:0]  dg_who [$];
  dir_row_t    dir_tbl [$];

  int          fail_cnt = 0;
  int          idle_cycles = 0;
  int          rx_hold = 0;
  bit          no_idle = 1'b0;
  bit          pred_has;
  ack_t        pred_ack;
  ack_t        got_ack;

  gbn_receiver_checksum DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (cur_req.data),
    .s_axis_tuser  (cur_req.client),
    .s_axis_tlast  (cur_req.last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Gap length: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 65) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    if (r < 98) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  function automatic void clear_parser();
    prs_phase = PH_SEQ;
    for (int k = 0; k < 3; k++) fld_val[k] = '0;
    pay_sum   = '0;
    got_digit = 1'b0;
    fmt_bad   = 1'b0;
  endfunction

  // Appends to the tail of the datagram text, client and table queues.
  function automatic void add_txt(input logic [7:0] b);
    dg_txt.insert(dg_txt.size(), b);
  endfunction

  function automatic void add_who(input logic [3:0] c);
    dg_who.insert(dg_who.size(), c);
  endfunction

  function automatic void add_row(input dir_row_t r);
    dir_tbl.insert(dir_tbl.size(), r);
  endfunction

  // Parses one byte; on the last byte judges the datagram and returns the
  // acknowledgement it earns, if any.
  function automatic void ack_predict(input logic [3:0] cl, input logic [7:0] b,
                                      input logic last, output bit has,
                                      output ack_t res);
    int unsigned v;
    int          k;
    logic [7:0]  want;
    bit          ok;
    bit          hit;
    has = 1'b0;
    res = '0;
    if (prs_phase == PH_SEQ || prs_phase == PH_ACK || prs_phase == PH_CHK) begin
      k = (prs_phase == PH_SEQ) ? 0 : (prs_phase == PH_ACK) ? 1 : 2;
      if (b == CHAR_BAR) begin
        if (!got_digit) fmt_bad = 1'b1;
        got_digit = 1'b0;
        prs_phase = phase_e'(prs_phase << 1);
      end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
        got_digit = 1'b1;
        v = 32'(fld_val[k]) * 32'd10 + 32'(b - CHAR_ZERO);
        // The field saturates one above the sequence range.
        if (v > SEQ_TOP) begin
          v = SEQ_TOP + 1;
          fmt_bad = 1'b1;
        end
        fld_val[k] = 17'(v);
      end else begin
        fmt_bad = 1'b1;
      end
    end else if (prs_phase == PH_PAY) begin
      if (b == CHAR_PAD) prs_phase = PH_PAD;
      else pay_sum = pay_sum + b;
    end
    if (last) begin
      // With 16 clients every 4-bit index is in range.
      ok   = !fmt_bad && (prs_phase == PH_PAY || prs_phase == PH_PAD);
      want = 8'd255 - 8'(fld_val[0] + fld_val[1] + 17'(pay_sum));
      if (ok && fld_val[2] != 17'(want)) ok = 1'b0;
      if (ok) begin
        hit = (fld_val[0][15:0] == seq_expected[cl]);
        if (hit) seq_expected[cl] = seq_expected[cl] + 16'd1;
        has        = 1'b1;
        res.client = cl;
        res.ack    = seq_expected[cl];
        res.csum   = 8'd255 - (seq_expected[cl][7:0] + ACK_PAYLOAD_SUM);
        res.in_ord = hit;
      end
      clear_parser();
    end
  endfunction

  function automatic dir_row_t mk_row(input string text, input logic [3:0] client,
                                      input bit mixed, input bit typed, input bit has,
                                      input logic [15:0] ack, input logic [7:0] csum,
                                      input bit in_ord);
    dir_row_t r;
    r.text   = text;
    r.client = client;
    r.mixed  = mixed;
    r.typed  = typed;
    r.has    = has;
    r.ack    = ack;
    r.csum   = csum;
    r.in_ord = in_ord;
    return r;
  endfunction

  // Receiver side: random stalls unless a quiet stretch is running.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      m_ready <= 1'b0;
    end else begin
      rx_hold <= no_idle ? 0 : pick_gap();
      m_ready <= 1'b1;
    end
  end

  // Prediction on accepted bytes, checking on accepted acknowledgements.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        ack_predict(cur_req.client, cur_req.data, cur_req.last, pred_has, pred_ack);
        if (cur_req.typed && cur_req.last) begin
          pred_has = cur_req.typed_has;
          pred_ack = cur_req.typed_exp;
        end
        if (pred_has) ack_expect_q.insert(ack_expect_q.size(), pred_ack);
      end
      if (m_valid && m_ready) begin
        got_ack = {m_tuser[3:0], m_tdata[15:0], m_tdata[23:16], m_tuser[4]};
        if (ack_expect_q.size() == 0) begin
          $error("unexpected ack: client_id %0d ack_number %0d", got_ack.client,
                 got_ack.ack);
          fail_cnt++;
        end else begin
          pred_ack = ack_expect_q.pop_front();
          if (got_ack.client != pred_ack.client) begin
            $error("client_id: expected %0d, actual %0d", pred_ack.client, got_ack.client);
            fail_cnt++;
          end
          if (got_ack.ack != pred_ack.ack) begin
            $error("ack_number: expected %0d, actual %0d", pred_ack.ack, got_ack.ack);
            fail_cnt++;
          end
          if (got_ack.csum != pred_ack.csum) begin
            $error("ack_checksum: expected %0d, actual %0d", pred_ack.csum, got_ack.csum);
            fail_cnt++;
          end
          if (got_ack.in_ord != pred_ack.in_ord) begin
            $error("in_order: expected %0d, actual %0d", pred_ack.in_ord, got_ack.in_ord);
            fail_cnt++;
          end
        end
      end
      if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles without any accepted request.
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Sends one byte request after an optional gap and waits for acceptance.
  task automatic put_byte(input byte_req_t req);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    cur_req <= req;
    do @(posedge clk_i); while (!s_ready);
  endtask

  task automatic send_datagram(input bit typed, input bit has, input ack_t exp);
    byte_req_t req;
    for (int i = 0; i < dg_txt.size(); i++) begin
      req.client    = dg_who[i];
      req.data      = dg_txt[i];
      req.last      = (i == dg_txt.size() - 1);
      req.typed     = typed;
      req.typed_has = has;
      req.typed_exp = exp;
      put_byte(req);
    end
  endtask

  // Holds the sender off until every pending acknowledgement has arrived.
  task automatic drain_acks();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (ack_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // Builds a random datagram, mostly well formed, aimed at the client's
  // current sequence number.
  task automatic make_datagram();
    logic [3:0]  c;
    logic [15:0] seq_v;
    logic [15:0] ack_v;
    logic [7:0]  csum_v;
    logic [7:0]  psum;
    logic [7:0]  ch;
    logic [7:0]  pay [$];
    int          pick;
    int          bk;
    int          cut;
    bit          padded;
    bit          mixed;
    flaw_e       flaw;
    string       fld [3];
    dg_txt.delete();
    dg_who.delete();
    c    = 4'($urandom_range(0, 15));
    pick = int'($urandom_range(0, 99));
    if (pick < 60) seq_v = seq_expected[c];
    else if (pick < 75) seq_v = seq_expected[c] - 16'd1;
    else if (pick < 95) seq_v = 16'($urandom_range(0, 65535));
    else seq_v = 16'hFFFF;
    ack_v = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                 : 16'($urandom_range(0, 9));
    repeat ($urandom_range(0, 6)) pay.insert(pay.size(), 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0) begin
      pay.insert(int'($urandom_range(0, pay.size())), CHAR_PAD);
      pay.insert(pay.size(), 8'($urandom_range(0, 255)));
    end
    // The payload counts up to the first pad character.
    padded = 1'b0;
    psum   = '0;
    foreach (pay[i]) begin
      if (!padded) begin
        if (pay[i] == CHAR_PAD) padded = 1'b1;
        else psum = psum + pay[i];
      end
    end
    csum_v = 8'd255 - 8'(seq_v + ack_v + 16'(psum));
    if ($urandom_range(0, 9) == 0) csum_v = csum_v + 8'($urandom_range(1, 255));
    fld[0] = $sformatf("%0d", seq_v);
    fld[1] = $sformatf("%0d", ack_v);
    fld[2] = $sformatf("%0d", csum_v);
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 7) == 0) fld[k] = {"00", fld[k]};
    end
    flaw = ($urandom_range(0, 99) < 15) ? flaw_e'($urandom_range(1, 5)) : FL_NONE;
    bk   = int'($urandom_range(0, 2));
    if (flaw == FL_EMPTY) fld[bk] = "";
    if (flaw == FL_BIG) begin
      fld[bk] = $urandom_range(0, 1) ? "65536" : $sformatf("%0d", $urandom_range(65537, 9999999));
    end
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < fld[k].len(); i++) add_txt(fld[k][i]);
      if (flaw == FL_CHAR && k == bk) begin
        do ch = 8'($urandom_range(0, 255));
        while ((ch >= CHAR_ZERO && ch <= CHAR_NINE) || ch == CHAR_BAR);
        add_txt(ch);
      end
      add_txt(CHAR_BAR);
    end
    foreach (pay[i]) add_txt(pay[i]);
    if (flaw == FL_CUT) begin
      cut = int'($urandom_range(1, dg_txt.size() - 1));
      while (dg_txt.size() > cut) void'(dg_txt.pop_back());
    end
    if (flaw == FL_NOISE) begin
      dg_txt.delete();
      repeat ($urandom_range(1, 8)) add_txt(8'($urandom_range(0, 255)));
    end
    // Now and then the client index wanders before the last byte.
    mixed = ($urandom_range(0, 9) == 0);
    foreach (dg_txt[i]) begin
      if (mixed && i != dg_txt.size() - 1) add_who(4'($urandom_range(0, 15)));
      else add_who(c);
    end
  endtask

  initial begin
    ack_t exp;
    int   sent;
    bit   paused;
    clear_parser();
    for (int i = 0; i < 16; i++) seq_expected[i] = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed datagrams; hand-typed outcomes hold right after reset.
    add_row(mk_row("0|0|255|", 4'd0, 0, 1, 1, 16'd1, 8'd47, 1));
    add_row(mk_row("0|0|255|", 4'd0, 0, 1, 1, 16'd1, 8'd47, 0));
    add_row(mk_row("1|0|254|", 4'd0, 0, 1, 1, 16'd2, 8'd46, 1));
    add_row(mk_row("1a|0|0|", 4'd0, 0, 1, 0, 16'd0, 8'd0, 0));
    add_row(mk_row("7|x|0|", 4'd0, 0, 1, 0, 16'd0, 8'd0, 0));
    add_row(mk_row("0|0|2x55|", 4'd0, 0, 1, 0, 16'd0, 8'd0, 0));
    add_row(mk_row("|0|255|", 4'd0, 0, 1, 0, 16'd0, 8'd0, 0));
    add_row(mk_row("2|0|253", 4'd0, 0, 1, 0, 16'd0, 8'd0, 0));
    add_row(mk_row("65536|0|255|", 4'd0, 0, 1, 0, 16'd0, 8'd0, 0));
    add_row(mk_row("2|0|0|", 4'd0, 0, 1, 0, 16'd0, 8'd0, 0));
    add_row(mk_row("65535|65535|1|", 4'd15, 0, 1, 1, 16'd0, 8'd48, 0));
    add_row(mk_row("|", 4'd3, 0, 1, 0, 16'd0, 8'd0, 0));
    add_row(mk_row("2|9|181|a|b#zz", 4'd0, 0, 0, 0, 16'd0, 8'd0, 0));
    add_row(mk_row("3|0|252|", 4'd0, 1, 0, 0, 16'd0, 8'd0, 0));
    add_row(mk_row("0004|00|0251|", 4'd0, 0, 0, 0, 16'd0, 8'd0, 0));
    add_row(mk_row("0|1|255|\377", 4'd7, 0, 0, 0, 16'd0, 8'd0, 0));
    add_row(mk_row("5|0|250|#abc", 4'd0, 0, 0, 0, 16'd0, 8'd0, 0));

    foreach (dir_tbl[r]) begin
      dg_txt.delete();
      dg_who.delete();
      for (int i = 0; i < dir_tbl[r].text.len(); i++) begin
        add_txt(dir_tbl[r].text[i]);
        if (dir_tbl[r].mixed && i != dir_tbl[r].text.len() - 1)
          add_who(4'($urandom_range(0, 15)));
        else
          add_who(dir_tbl[r].client);
      end
      exp = {dir_tbl[r].client, dir_tbl[r].ack, dir_tbl[r].csum, dir_tbl[r].in_ord};
      send_datagram(dir_tbl[r].typed, dir_tbl[r].has, exp);
    end
    drain_acks();

    // Random datagrams, with one quiet stretch and one full drain midway.
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_BYTES) begin
      no_idle = (sent >= 500 && sent < 800);
      if (!paused && sent >= 1100) begin
        drain_acks();
        paused = 1'b1;
      end
      make_datagram();
      sent += dg_txt.size();
      send_datagram(1'b0, 1'b0, '0);
    end
    no_idle = 1'b0;
    drain_acks();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/gbr_pkg.sv
sv/gbr_front.sv
sv/gbr_queue.sv
sv/gbr_back.sv
sv/gbn_receiver_checksum.sv
dv/tb_top.sv
